[hdl/srg_pkg.sv]
`timescale 1ns / 1ps

package srg_pkg;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 34;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MOVE  = 2'd1,
    OP_SPEED = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_ACCEL       = 3'd1,
    REG_FIRST_INT   = 3'd2,
    REG_PULSE_WIDTH = 3'd3,
    REG_RAMP_MODE   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SQ, S_STOP_GO, S_STOP_WAIT, S_CMIN_GO, S_CMIN_WAIT,
    S_DECIDE, S_EQ_GO, S_EQ_WAIT, S_SPD, S_SPD_GO, S_SPD_WAIT,
    S_SET_GO, S_SET_WAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  localparam logic [DIV_NW-1:0] CMIN_NUM  = 40'd256000000;
  localparam logic [DIV_NW-1:0] SPEED_NUM = 40'd65536000000;
  localparam logic [DIV_NW-1:0] SET_NUM   = 40'd1000000;
  localparam logic [DIV_NW-1:0] SPEED_CAP = 40'd256000000;

endpackage

[hdl/srg_div.sv]
`timescale 1ns / 1ps

module srg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  srg_pkg::div_req_t         req,
  output logic                      done,
  output logic [srg_pkg::DIV_NW-1:0] quotient
);
  import srg_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial    = {rem, quo[DIV_NW-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        cnt  <= DIV_CW'(DIV_NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIV_NW-2:0], ge};
        rem <= ge ? DIV_DW'(trial - {1'b0, dsr}) : trial[DIV_DW-1:0];
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

[hdl/stepper_ramp_generator.sv]
`timescale 1ns / 1ps
// One word is taken at a time; the input stalls until its result is registered.
// A tick without a step or a plain command goes through S_EXEC and S_DONE only.
// A speed command that changes the rate runs one division on the shared divider.
// A ramp recompute runs up to four divisions in turn on the shared divider.
// Synchronous reset clears the motion state and loads the register defaults.

module stepper_ramp_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] target_position,
  input  logic signed [16:0] speed_command,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               step_out,
  output logic               dir_out,
  output logic signed [31:0] position_now,
  output logic               moving,
  output logic signed [20:0] speed_now,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import srg_pkg::*;

  localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;

  logic [15:0] max_speed, acceleration;
  logic [23:0] first_interval;
  logic [7:0]  min_pulse_width;
  logic        ramp_mode;

  logic [31:0]        position, target;
  logic [23:0]        step_interval;
  logic [31:0]        ramp_interval;
  logic signed [28:0] signed_speed;
  logic signed [31:0] ramp_count;
  logic               direction_bit;
  logic [31:0]        elapsed_us;
  logic [7:0]         pulse_left;

  logic [1:0]         op_r;
  logic [31:0]        tgt_r;
  logic signed [16:0] cmd_r;
  logic [55:0]        sq_r;
  logic signed [32:0] dist_r;
  logic [30:0]        stop_r;
  logic [27:0]        cmin_r;

  state_t state, state_next;
  div_req_t req;
  logic div_done;
  logic [DIV_NW-1:0] div_q;

  srg_div u_div (.clk(clk), .rst(rst), .req(req), .done(div_done), .quotient(div_q));

  logic [15:0] acc_eff, max_eff;
  logic [31:0] el_inc;
  logic        step_hit;
  logic signed [28:0] cmd256;
  logic signed [17:0] lim, cmd_x, cmd_c;
  logic [16:0] cmd_mag;
  logic [27:0] mag;
  logic signed [33:0] dist34, ndist34, stop34;
  logic signed [31:0] neg_stop, neg_rc, rc_dec, rc_inc;
  logic signed [34:0] den, den_abs, cn35, nv;
  logic [31:0] nv_c;
  logic out_free;
  logic signed [28:0] spd_adj;

  assign acc_eff  = (acceleration == '0) ? 16'd1 : acceleration;
  assign max_eff  = (max_speed == '0) ? 16'd1 : max_speed;
  assign el_inc   = (elapsed_us == 32'hFFFFFFFF) ? elapsed_us : elapsed_us + 32'd1;
  assign step_hit = (step_interval != '0) && (el_inc >= {8'd0, step_interval});
  assign cmd256   = {{4{cmd_r[16]}}, cmd_r, 8'd0};
  assign lim      = {2'b00, max_eff};
  assign cmd_x    = {cmd_r[16], cmd_r};
  assign cmd_c    = (cmd_x > lim) ? lim : ((cmd_x < -lim) ? -lim : cmd_x);
  assign cmd_mag  = cmd_r[16] ? 17'(-cmd_r) : 17'(cmd_r);
  assign mag      = signed_speed[28] ? 28'(-signed_speed) : 28'(signed_speed);

  assign dist34   = {dist_r[32], dist_r};
  assign ndist34  = -dist34;
  assign stop34   = {3'b000, stop_r};
  assign neg_stop = -$signed({1'b0, stop_r});
  assign neg_rc   = (ramp_count == I32_MIN) ? I32_MAX : -ramp_count;
  assign rc_inc   = (ramp_count == I32_MAX) ? I32_MAX : ramp_count + 32'sd1;

  always_comb begin
    rc_dec = ramp_count;
    if (dist_r > 0) begin
      if (ramp_count > 0) begin
        if (stop34 >= dist34 || direction_bit) rc_dec = neg_stop;
      end else if (ramp_count < 0) begin
        if (stop34 < dist34 && !direction_bit) rc_dec = neg_rc;
      end
    end else if (dist_r < 0) begin
      if (ramp_count > 0) begin
        if (stop34 >= ndist34 || !direction_bit) rc_dec = neg_stop;
      end else if (ramp_count < 0) begin
        if (stop34 < ndist34 && direction_bit) rc_dec = neg_rc;
      end
    end
  end

  assign den     = {ramp_count[31], ramp_count, 2'b00} + 35'sd1;
  assign den_abs = den[34] ? -den : den;
  assign cn35    = {3'b000, ramp_interval};
  assign nv      = den[34] ? cn35 + $signed({2'b00, div_q[32:0]})
                           : cn35 - $signed({2'b00, div_q[32:0]});

  always_comb begin
    if (nv < 0) nv_c = '0;
    else if (nv > 35'sh0FFFFFFFF) nv_c = 32'hFFFFFFFF;
    else nv_c = nv[31:0];
    if (nv_c < {4'd0, cmin_r}) nv_c = {4'd0, cmin_r};
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        case (op_r)
          OP_TICK:  if (step_hit && ramp_mode) state_next = S_SQ;
          OP_MOVE:  if (tgt_r != target) state_next = S_SQ;
          OP_SPEED: if (cmd256 != signed_speed && cmd_c != 0) state_next = S_SET_GO;
          default:  state_next = S_DONE;
        endcase
      end
      S_SQ:        state_next = S_STOP_GO;
      S_STOP_GO:   state_next = S_STOP_WAIT;
      S_STOP_WAIT: if (div_done) state_next = S_CMIN_GO;
      S_CMIN_GO:   state_next = S_CMIN_WAIT;
      S_CMIN_WAIT: if (div_done) state_next = S_DECIDE;
      S_DECIDE: begin
        if (dist_r == 0 && stop_r <= 31'd1) state_next = S_DONE;
        else if (rc_dec == 0) state_next = S_SPD;
        else state_next = S_EQ_GO;
      end
      S_EQ_GO:    state_next = S_EQ_WAIT;
      S_EQ_WAIT:  if (div_done) state_next = S_SPD;
      S_SPD:      state_next = (ramp_interval == '0) ? S_DONE : S_SPD_GO;
      S_SPD_GO:   state_next = S_SPD_WAIT;
      S_SPD_WAIT: if (div_done) state_next = S_DONE;
      S_SET_GO:   state_next = S_SET_WAIT;
      S_SET_WAIT: if (div_done) state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.start    = 1'b0;
    req.dividend = '0;
    req.divisor  = '0;
    unique case (state)
      S_STOP_GO, S_STOP_WAIT: begin
        req.start    = (state == S_STOP_GO);
        req.dividend = {1'b0, sq_r[55:17]};
        req.divisor  = {18'd0, acc_eff};
      end
      S_CMIN_GO, S_CMIN_WAIT: begin
        req.start    = (state == S_CMIN_GO);
        req.dividend = CMIN_NUM;
        req.divisor  = {18'd0, max_eff};
      end
      S_EQ_GO, S_EQ_WAIT: begin
        req.start    = (state == S_EQ_GO);
        req.dividend = {7'd0, ramp_interval, 1'b0};
        req.divisor  = {1'b0, den_abs[32:0]};
      end
      S_SPD_GO, S_SPD_WAIT: begin
        req.start    = (state == S_SPD_GO);
        req.dividend = SPEED_NUM;
        req.divisor  = {2'd0, ramp_interval};
      end
      S_SET_GO, S_SET_WAIT: begin
        req.start    = (state == S_SET_GO);
        req.dividend = SET_NUM;
        req.divisor  = {17'd0, cmd_mag};
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed       <= 16'd10;
      acceleration    <= 16'd1;
      first_interval  <= '0;
      min_pulse_width <= 8'd1;
      ramp_mode       <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_SPEED:   max_speed       <= cfg_data[15:0];
        REG_ACCEL:       acceleration    <= cfg_data[15:0];
        REG_FIRST_INT:   first_interval  <= cfg_data;
        REG_PULSE_WIDTH: min_pulse_width <= cfg_data[7:0];
        REG_RAMP_MODE:   ramp_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      target        <= '0;
      step_interval <= '0;
      ramp_interval <= '0;
      signed_speed  <= '0;
      ramp_count    <= '0;
      direction_bit <= 1'b1;
      elapsed_us    <= '0;
      pulse_left    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          op_r  <= op;
          tgt_r <= target_position;
          cmd_r <= speed_command;
        end
        S_EXEC: begin
          case (op_r)
            OP_TICK: begin
              if (pulse_left != '0) pulse_left <= pulse_left - 8'd1;
              elapsed_us <= el_inc;
              if (step_hit) begin
                position   <= direction_bit ? position - 32'd1 : position + 32'd1;
                pulse_left <= min_pulse_width;
                elapsed_us <= '0;
              end
            end
            OP_MOVE: if (tgt_r != target) target <= tgt_r;
            OP_SPEED: begin
              if (cmd256 != signed_speed) begin
                cmd_r        <= cmd_c[16:0];
                signed_speed <= {{3{cmd_c[17]}}, cmd_c, 8'd0};
                if (cmd_c == 0) step_interval <= '0;
                else direction_bit <= cmd_c[17];
              end
            end
            default: ;
          endcase
        end
        S_SQ: begin
          sq_r   <= mag * mag;
          dist_r <= $signed({target[31], target}) - $signed({position[31], position});
        end
        S_STOP_WAIT:
          if (div_done) stop_r <= (div_q > 40'h007FFFFFFF) ? 31'h7FFFFFFF : div_q[30:0];
        S_CMIN_WAIT: if (div_done) cmin_r <= div_q[27:0];
        S_DECIDE: begin
          if (dist_r == 0 && stop_r <= 31'd1) begin
            step_interval <= '0;
            signed_speed  <= '0;
            ramp_count    <= '0;
          end else if (rc_dec == 0) begin
            ramp_interval <= {first_interval, 8'd0};
            direction_bit <= !(dist_r > 0);
            ramp_count    <= 32'sd1;
          end else begin
            ramp_count <= rc_dec;
          end
        end
        S_EQ_WAIT: begin
          if (div_done) begin
            ramp_interval <= nv_c;
            ramp_count    <= rc_inc;
          end
        end
        S_SPD: begin
          step_interval <= ramp_interval[31:8];
          if (ramp_interval == '0) signed_speed <= '0;
        end
        S_SPD_WAIT: begin
          if (div_done) begin
            signed_speed <= direction_bit
              ? -$signed({1'b0, ((div_q > SPEED_CAP) ? SPEED_CAP[27:0] : div_q[27:0])})
              :  $signed({1'b0, ((div_q > SPEED_CAP) ? SPEED_CAP[27:0] : div_q[27:0])});
          end
        end
        S_SET_WAIT: if (div_done) step_interval <= div_q[23:0];
        default: ;
      endcase
    end
  end

  assign spd_adj = signed_speed + (signed_speed[28] ? 29'sd255 : 29'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_DONE && out_free) begin
        out_valid    <= 1'b1;
        step_out     <= (pulse_left != '0);
        dir_out      <= direction_bit;
        position_now <= position;
        moving       <= (signed_speed != 0) || (target != position);
        speed_now    <= spd_adj[28:8];
      end
    end
  end

endmodule

[dv/stepper_ramp_generator_tb.sv]
`timescale 1ns / 1ps

module stepper_ramp_generator_tb;
  import srg_pkg::*;

  typedef struct packed {
    logic               step;
    logic               dir;
    logic signed [31:0] pos;
    logic               mov;
    logic signed [20:0] spd;
  } motion_t;

  class motion_scoreboard;
    longint unsigned max_speed, accel, first_int, pulse_width, ramp_on;
    logic [31:0] position, target;
    logic [31:0] step_int;
    longint unsigned ramp_int;
    longint signed spd_q8, ramp_cnt;
    bit dir_bit;
    logic [31:0] elapsed, pulse_left;
    motion_t pending[$];
    int mismatches;

    function void reset_state();
      max_speed = 10; accel = 1; first_int = 0; pulse_width = 1; ramp_on = 0;
      position = 0; target = 0; step_int = 0; ramp_int = 0; spd_q8 = 0;
      ramp_cnt = 0; dir_bit = 1; elapsed = 0; pulse_left = 0;
      pending.delete(); mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [23:0] val);
      case (idx)
        REG_MAX_SPEED:   max_speed = val[15:0];
        REG_ACCEL:       accel = val[15:0];
        REG_FIRST_INT:   first_int = val;
        REG_PULSE_WIDTH: pulse_width = val[7:0];
        REG_RAMP_MODE:   ramp_on = val[0];
        default: ;
      endcase
    endfunction

    function longint signed sat_cnt(longint signed v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned limit_speed();
      return (max_speed != 0) ? max_speed : 1;
    endfunction

    function void recompute();
      longint signed dist_v, stop, cn, nv;
      longint unsigned mag, acc, stop_u, cmin, q;
      dist_v = longint'($signed(target)) - longint'($signed(position));
      mag = (spd_q8 < 0) ? -spd_q8 : spd_q8;
      acc = (accel != 0) ? accel : 1;
      stop_u = (mag * mag) / (2 * acc * 65536);
      stop = (stop_u > 2147483647) ? 2147483647 : stop_u;
      cmin = 256000000 / limit_speed();
      if (dist_v == 0 && stop <= 1) begin
        step_int = 0; spd_q8 = 0; ramp_cnt = 0;
        return;
      end
      if (dist_v > 0) begin
        if (ramp_cnt > 0) begin
          if (stop >= dist_v || dir_bit) ramp_cnt = -stop;
        end else if (ramp_cnt < 0) begin
          if (stop < dist_v && !dir_bit) ramp_cnt = sat_cnt(-ramp_cnt);
        end
      end else if (dist_v < 0) begin
        if (ramp_cnt > 0) begin
          if (stop >= -dist_v || !dir_bit) ramp_cnt = -stop;
        end else if (ramp_cnt < 0) begin
          if (stop < -dist_v && dir_bit) ramp_cnt = sat_cnt(-ramp_cnt);
        end
      end
      if (ramp_cnt == 0) begin
        ramp_int = first_int << 8;
        dir_bit = (dist_v > 0) ? 0 : 1;
      end else begin
        cn = ramp_int;
        nv = cn - (2 * cn) / (4 * ramp_cnt + 1);
        if (nv < 0) nv = 0;
        if (nv > 64'sd4294967295) nv = 64'sd4294967295;
        if (longint'(nv) < longint'(cmin)) nv = cmin;
        ramp_int = nv;
      end
      ramp_cnt = sat_cnt(ramp_cnt + 1);
      step_int = ((ramp_int >> 8) > 24'hFFFFFF) ? 32'hFFFFFF : 32'(ramp_int >> 8);
      if (ramp_int == 0) spd_q8 = 0;
      else begin
        q = 64'd65536000000 / ramp_int;
        if (q > 256000000) q = 256000000;
        spd_q8 = dir_bit ? -longint'(q) : longint'(q);
      end
    endfunction

    function void note_word(op_t o, logic [31:0] tgt, logic signed [16:0] cmd);
      longint signed c, lim;
      motion_t m;
      case (o)
        OP_TICK: begin
          if (pulse_left != 0) pulse_left--;
          if (elapsed != 32'hFFFFFFFF) elapsed++;
          if (step_int != 0 && elapsed >= step_int) begin
            position = dir_bit ? position - 1 : position + 1;
            pulse_left = 32'(pulse_width); elapsed = 0;
            if (ramp_on != 0) recompute();
          end
        end
        OP_MOVE: if (tgt != target) begin
          target = tgt; recompute();
        end
        OP_SPEED: begin
          c = cmd; lim = limit_speed();
          if (c * 256 != spd_q8) begin
            if (c > lim) c = lim;
            if (c < -lim) c = -lim;
            if (c == 0) step_int = 0;
            else begin
              step_int = 32'(1000000 / ((c < 0) ? -c : c));
              dir_bit = (c > 0) ? 0 : 1;
            end
            spd_q8 = c * 256;
          end
        end
        default: ;
      endcase
      m.step = (pulse_left != 0); m.dir = dir_bit; m.pos = position;
      m.mov = (spd_q8 != 0 || target != position);
      m.spd = 21'(spd_q8 / 256);
      pending.push_back(m);
    endfunction

    function void check_word(motion_t got);
      motion_t exp_m;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %p", got);
        return;
      end
      exp_m = pending.pop_front();
      if (got !== exp_m) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch at %0t: expected %p, got %p", $realtime, exp_m, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] op;
  logic signed [31:0] target_position;
  logic signed [16:0] speed_command;
  logic step_out, dir_out, moving;
  logic signed [31:0] position_now;
  logic signed [20:0] speed_now;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;

  motion_scoreboard sb;
  int send_idle_pct, stall_pct, idle_cycles;
  bit timed_out;

  stepper_ramp_generator uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word('{step_out, dir_out, position_now, moving, speed_now});
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("** stepper_ramp_generator: FAILED **");
      $finish;
    end
  end

  task automatic send_word(op_t o, logic [31:0] tgt, logic signed [16:0] cmd);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    @(posedge clk);
    in_valid <= 1'b1; op <= o; target_position <= tgt; speed_command <= cmd;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_word(o, tgt, cmd);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] val);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic ticks(int n);
    repeat (n) send_word(OP_TICK, $urandom, 17'($urandom));
  endtask

  task automatic random_words(int n, int span);
    int r;
    logic signed [16:0] cmd;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 80) send_word(OP_TICK, $urandom, 17'($urandom));
      else if (r < 90)
        send_word(OP_MOVE, $signed(sb.position) + $signed($urandom_range(2 * span) - span),
                  17'($urandom));
      else if (r < 93) send_word(OP_MOVE, $urandom, 17'($urandom));
      else begin
        cmd = 17'($signed($urandom_range(131070)) - 17'sd65535);
        if ($urandom_range(1)) cmd = cmd % 17'sd5000;
        send_word(OP_SPEED, $urandom, cmd);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    timed_out = 0; idle_cycles = 0;
    send_idle_pct = 0; stall_pct = 0;
    rst = 1; in_valid = 0; op = OP_TICK; target_position = 0; speed_command = 0;
    cfg_we = 0; cfg_index = REG_MAX_SPEED; cfg_data = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset defaults, extremes of commands and the unused opcode.
    send_word(OP_MOVE, 32'sd5, 17'sd0);
    ticks(3);
    send_word(OP_SPEED, 0, 17'sd65535);
    ticks(2);
    send_word(OP_SPEED, 0, -17'sd65535);
    send_word(OP_SPEED, 0, -17'sd10);
    send_word(op_t'(2'd3), 32'h7FFFFFFF, 17'sh10000);
    send_word(OP_SPEED, 0, 17'sd0);
    send_word(OP_MOVE, 32'sh80000000, 17'sd0);
    send_word(OP_MOVE, 32'sh7FFFFFFF, 17'sd0);
    send_word(OP_MOVE, 32'sh7FFFFFFF, 17'sd0);
    write_reg(REG_MAX_SPEED, 24'd65535);
    write_reg(REG_PULSE_WIDTH, 24'd255);
    send_word(OP_SPEED, 0, 17'sd65535);
    ticks(6);
    write_reg(REG_PULSE_WIDTH, 24'd0);
    send_word(OP_SPEED, 0, -17'sd60000);
    ticks(4);
    send_word(OP_SPEED, 0, 17'sd0);

    // Phases across settings, ramp mode off in the first, cycling through four idling styles.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      write_reg(REG_RAMP_MODE, (ph == 0) ? 24'd0 : 24'd1);
      write_reg(REG_MAX_SPEED, (ph == 1) ? 24'd0 : (ph == 2) ? 24'd65535
                : 24'($urandom_range(20000, 100)));
      write_reg(REG_ACCEL, (ph == 3) ? 24'd0 : (ph == 4) ? 24'd65535
                : 24'($urandom_range(5000, 1)));
      write_reg(REG_FIRST_INT, (ph == 5) ? 24'hFFFFFF : (ph == 2) ? 24'd0
                : 24'($urandom_range(40, 2)));
      write_reg(REG_PULSE_WIDTH, (ph == 4) ? 24'd255 : 24'($urandom_range(4, 1)));
      send_word(OP_SPEED, 0, 17'sd0);
      random_words(250, 30);
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("** stepper_ramp_generator: PASSED **");
    else
      $display("** stepper_ramp_generator: FAILED **");
    $finish;
  end

endmodule
